>>> hdl/skn64_pkg.sv
package skn64_pkg;

  localparam int MAX_ROUNDS = 3;
  localparam int ROUNDS_W   = 2;
  localparam int CELLS      = 16;
  localparam int KEY_CELLS  = 8;

  typedef logic [63:0] word_t;
  typedef logic [3:0]  cell_t;

  typedef enum logic [2:0] {
    CFG_NUM_ROUNDS = 3'd0,
    CFG_BEFORE_R0  = 3'd1,
    CFG_AFTER_R0   = 3'd2,
    CFG_BEFORE_R1  = 3'd3,
    CFG_AFTER_R1   = 3'd4,
    CFG_BEFORE_R2  = 3'd5,
    CFG_AFTER_R2   = 3'd6
  } cfg_idx_t;

  // Result of one round on one state of the pair.
  typedef struct packed {
    word_t sbox_out;
    word_t state;
    word_t key;
  } round_out_t;

  localparam cell_t SBOX [CELLS] = '{
    4'hc, 4'h6, 4'h9, 4'h0, 4'h1, 4'ha, 4'h2, 4'hb,
    4'h3, 4'h8, 4'h5, 4'hd, 4'h4, 4'he, 4'h7, 4'hf
  };

  localparam cell_t ROW_SHIFT_SRC [CELLS] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd7, 4'd4, 4'd5, 4'd6,
    4'd10, 4'd11, 4'd8, 4'd9, 4'd13, 4'd14, 4'd15, 4'd12
  };

  localparam cell_t TK_PERM_SRC [CELLS] = '{
    4'd9, 4'd15, 4'd8, 4'd13, 4'd10, 4'd14, 4'd12, 4'd11,
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7
  };

endpackage

>>> hdl/skn64_round.sv
module skn64_round (
  input  skn64_pkg::word_t      state_in,
  input  skn64_pkg::word_t      key_in,
  output skn64_pkg::round_out_t rnd_out
);

  skn64_pkg::word_t sb;
  skn64_pkg::word_t kx;
  skn64_pkg::word_t sr;
  skn64_pkg::word_t mc;
  skn64_pkg::word_t kp;

  always_comb begin
    for (int i = 0; i < skn64_pkg::CELLS; i++) begin
      sb[4*i +: 4] = skn64_pkg::SBOX[state_in[4*i +: 4]];
    end

    kx = sb;
    for (int i = 0; i < skn64_pkg::KEY_CELLS; i++) begin
      kx[4*i +: 4] = sb[4*i +: 4] ^ key_in[4*i +: 4];
    end

    for (int i = 0; i < skn64_pkg::CELLS; i++) begin
      sr[4*i +: 4] = kx[4*skn64_pkg::ROW_SHIFT_SRC[i] +: 4];
      kp[4*i +: 4] = key_in[4*skn64_pkg::TK_PERM_SRC[i] +: 4];
    end

    // rows: 0 = r0^r2^r3, 1 = r0, 2 = r1^r2, 3 = r0^r2
    for (int j = 0; j < 4; j++) begin
      mc[4*j +: 4]      = sr[4*j +: 4] ^ sr[4*(j+8) +: 4] ^ sr[4*(j+12) +: 4];
      mc[4*(j+4) +: 4]  = sr[4*j +: 4];
      mc[4*(j+8) +: 4]  = sr[4*(j+4) +: 4] ^ sr[4*(j+8) +: 4];
      mc[4*(j+12) +: 4] = sr[4*j +: 4] ^ sr[4*(j+8) +: 4];
    end

    rnd_out.sbox_out = sb;
    rnd_out.state    = mc;
    rnd_out.key      = kp;
  end

endmodule

>>> hdl/skinny64_pair_trail_check.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | plaintext pair, tweakey pair (4 x 64)
// out_    | output    | out_valid/out_stall| trail_followed (1)
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index (3), cfg_data (64)
//
// One pair accepted per cycle while in_stall is low. The accepting edge loads the
// input register; the result register then takes the flag once it can advance.
// All three rounds of both states are evaluated in the single
// combinational path between those registers.
// rst_n is synchronous: it empties both stages and restores register defaults.
// in_stall rises only when both stages are full and out_stall holds the result.
module skinny64_pair_trail_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_first_plaintext,
  input  logic [63:0] in_second_plaintext,
  input  logic [63:0] in_first_tweakey,
  input  logic [63:0] in_second_tweakey,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_trail_followed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int NR = skn64_pkg::MAX_ROUNDS;

  logic [skn64_pkg::ROUNDS_W-1:0] num_rounds_r, num_rounds_nxt;
  skn64_pkg::word_t diff_before_r [NR];
  skn64_pkg::word_t diff_before_nxt [NR];
  skn64_pkg::word_t diff_after_r [NR];
  skn64_pkg::word_t diff_after_nxt [NR];

  logic             s1_valid_r, s1_valid_nxt;
  skn64_pkg::word_t pt1_r, pt2_r, tk1_r, tk2_r;
  logic             out_valid_r, out_valid_nxt;
  logic             trail_r, trail_nxt;

  logic s1_adv;
  logic in_take;

  skn64_pkg::word_t      st1 [NR+1];
  skn64_pkg::word_t      st2 [NR+1];
  skn64_pkg::word_t      key1 [NR+1];
  skn64_pkg::word_t      key2 [NR+1];
  skn64_pkg::round_out_t ro1 [NR];
  skn64_pkg::round_out_t ro2 [NR];
  logic [skn64_pkg::ROUNDS_W-1:0] rounds_eff;

  assign cfg_ready = 1'b1;

  always_comb begin
    num_rounds_nxt  = num_rounds_r;
    diff_before_nxt = diff_before_r;
    diff_after_nxt  = diff_after_r;
    if (cfg_valid) begin
      case (skn64_pkg::cfg_idx_t'(cfg_index))
        skn64_pkg::CFG_NUM_ROUNDS: num_rounds_nxt = cfg_data[skn64_pkg::ROUNDS_W-1:0];
        skn64_pkg::CFG_BEFORE_R0:  diff_before_nxt[0] = cfg_data;
        skn64_pkg::CFG_AFTER_R0:   diff_after_nxt[0]  = cfg_data;
        skn64_pkg::CFG_BEFORE_R1:  diff_before_nxt[1] = cfg_data;
        skn64_pkg::CFG_AFTER_R1:   diff_after_nxt[1]  = cfg_data;
        skn64_pkg::CFG_BEFORE_R2:  diff_before_nxt[2] = cfg_data;
        skn64_pkg::CFG_AFTER_R2:   diff_after_nxt[2]  = cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control
  assign s1_adv   = ~out_valid_r | ~out_stall;
  assign in_stall = s1_valid_r & ~s1_adv;
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt = in_take | (s1_valid_r & ~s1_adv);
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Round datapath
  assign st1[0]  = pt1_r;
  assign st2[0]  = pt2_r;
  assign key1[0] = tk1_r;
  assign key2[0] = tk2_r;

  for (genvar r = 0; r < NR; r++) begin : g_round
    skn64_round u_rnd1 (.state_in(st1[r]), .key_in(key1[r]), .rnd_out(ro1[r]));
    skn64_round u_rnd2 (.state_in(st2[r]), .key_in(key2[r]), .rnd_out(ro2[r]));
    assign st1[r+1]  = ro1[r].state;
    assign st2[r+1]  = ro2[r].state;
    assign key1[r+1] = ro1[r].key;
    assign key2[r+1] = ro2[r].key;
  end

  always_comb begin
    if (int'(num_rounds_r) > NR) begin
      rounds_eff = skn64_pkg::ROUNDS_W'(NR);
    end else begin
      rounds_eff = num_rounds_r;
    end
    trail_nxt = 1'b1;
    for (int r = 0; r < NR; r++) begin
      if (r < int'(rounds_eff)) begin
        if ((st1[r] ^ st2[r]) != diff_before_r[r] ||
            (ro1[r].sbox_out ^ ro2[r].sbox_out) != diff_after_r[r]) begin
          trail_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rounds_r <= skn64_pkg::ROUNDS_W'(NR);
      for (int r = 0; r < NR; r++) begin
        diff_before_r[r] <= '0;
        diff_after_r[r]  <= '0;
      end
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      num_rounds_r  <= num_rounds_nxt;
      diff_before_r <= diff_before_nxt;
      diff_after_r  <= diff_after_nxt;
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pt1_r <= in_first_plaintext;
      pt2_r <= in_second_plaintext;
      tk1_r <= in_first_tweakey;
      tk2_r <= in_second_tweakey;
    end
    if (s1_adv) begin
      trail_r <= trail_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_trail_followed = trail_r;

endmodule

>>> hdl/skn64_chk.sv
module skn64_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_trail_followed
);

  // held result stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_trail_followed))
    else $error("stalled result changed");

  // input backpressure only comes from a full, stalled output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without output backpressure");

  // an accepted transaction passes the input register and reaches the output register when out_stall is low
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted transaction did not reach the output");

endmodule

bind skinny64_pair_trail_check skn64_chk u_skn64_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_trail_followed(out_trail_followed)
);

>>> tb/sv/tb_skinny64_pair_trail_check.sv
`timescale 1ns / 100ps

// Tracks the configured differential trail and the flags still owed by the block.
class trail_tracker;
  // nibble i of each constant holds entry i of the table
  localparam skn64_pkg::word_t SBOX_NIBS = 64'hf7e4_d583_b2a1_096c;
  localparam skn64_pkg::word_t ROW_SRC   = 64'hcfed_98ba_6547_3210;
  localparam skn64_pkg::word_t TK_SRC    = 64'h7654_3210_bcea_d8f9;

  logic [skn64_pkg::ROUNDS_W-1:0] rounds_cfg;
  skn64_pkg::word_t want_before [skn64_pkg::MAX_ROUNDS];
  skn64_pkg::word_t want_after [skn64_pkg::MAX_ROUNDS];
  bit pending_flags [$];
  int pairs_checked;
  int trails_followed;
  int mismatches;

  function new();
    rounds_cfg = skn64_pkg::ROUNDS_W'(skn64_pkg::MAX_ROUNDS);
    foreach (want_before[r]) begin
      want_before[r] = '0;
      want_after[r] = '0;
    end
    pairs_checked = 0;
    trails_followed = 0;
    mismatches = 0;
  endfunction

  function skn64_pkg::word_t sub_cells(skn64_pkg::word_t w);
    skn64_pkg::word_t r;
    for (int i = 0; i < skn64_pkg::CELLS; i++)
      r[4*i +: 4] = SBOX_NIBS[4*w[4*i +: 4] +: 4];
    return r;
  endfunction

  function skn64_pkg::word_t permute_cells(skn64_pkg::word_t w, skn64_pkg::word_t src);
    skn64_pkg::word_t r;
    for (int i = 0; i < skn64_pkg::CELLS; i++)
      r[4*i +: 4] = w[4*src[4*i +: 4] +: 4];
    return r;
  endfunction

  function skn64_pkg::word_t mix_columns(skn64_pkg::word_t w);
    skn64_pkg::word_t r;
    skn64_pkg::cell_t row0, row1, row2, row3;
    for (int j = 0; j < 4; j++) begin
      row0 = w[4*j +: 4];
      row1 = w[4*(j+4) +: 4];
      row2 = w[4*(j+8) +: 4];
      row3 = w[4*(j+12) +: 4];
      r[4*j +: 4]      = row0 ^ row2 ^ row3;
      r[4*(j+4) +: 4]  = row0;
      r[4*(j+8) +: 4]  = row1 ^ row2;
      r[4*(j+12) +: 4] = row0 ^ row2;
    end
    return r;
  endfunction

  // Differences of the pair around the S-box, for every round the block can run.
  function void trace_diffs(input skn64_pkg::word_t p1, input skn64_pkg::word_t p2,
                            input skn64_pkg::word_t k1, input skn64_pkg::word_t k2,
                            output skn64_pkg::word_t bef [skn64_pkg::MAX_ROUNDS],
                            output skn64_pkg::word_t aft [skn64_pkg::MAX_ROUNDS]);
    skn64_pkg::word_t s1, s2, t1, t2;
    s1 = p1;
    s2 = p2;
    t1 = k1;
    t2 = k2;
    for (int r = 0; r < skn64_pkg::MAX_ROUNDS; r++) begin
      bef[r] = s1 ^ s2;
      s1 = sub_cells(s1);
      s2 = sub_cells(s2);
      aft[r] = s1 ^ s2;
      // only key cells 0..7 are added, before the key is permuted
      s1 = mix_columns(permute_cells(s1 ^ {32'h0, t1[31:0]}, ROW_SRC));
      s2 = mix_columns(permute_cells(s2 ^ {32'h0, t2[31:0]}, ROW_SRC));
      t1 = permute_cells(t1, TK_SRC);
      t2 = permute_cells(t2, TK_SRC);
    end
  endfunction

  function void write_reg(logic [2:0] idx, skn64_pkg::word_t data);
    case (idx)
      skn64_pkg::CFG_NUM_ROUNDS: rounds_cfg = data[skn64_pkg::ROUNDS_W-1:0];
      skn64_pkg::CFG_BEFORE_R0:  want_before[0] = data;
      skn64_pkg::CFG_AFTER_R0:   want_after[0] = data;
      skn64_pkg::CFG_BEFORE_R1:  want_before[1] = data;
      skn64_pkg::CFG_AFTER_R1:   want_after[1] = data;
      skn64_pkg::CFG_BEFORE_R2:  want_before[2] = data;
      skn64_pkg::CFG_AFTER_R2:   want_after[2] = data;
      default: ;
    endcase
  endfunction

  function void note_pair(skn64_pkg::word_t p1, skn64_pkg::word_t p2,
                          skn64_pkg::word_t k1, skn64_pkg::word_t k2);
    skn64_pkg::word_t bef [skn64_pkg::MAX_ROUNDS];
    skn64_pkg::word_t aft [skn64_pkg::MAX_ROUNDS];
    int live;
    bit ok;
    live = (rounds_cfg > skn64_pkg::MAX_ROUNDS) ? skn64_pkg::MAX_ROUNDS : int'(rounds_cfg);
    ok = 1'b1;
    trace_diffs(p1, p2, k1, k2, bef, aft);
    for (int r = 0; r < live; r++)
      if (bef[r] != want_before[r] || aft[r] != want_after[r])
        ok = 1'b0;
    pending_flags.push_back(ok);
  endfunction

  function void check_flag(logic got);
    bit want;
    if (pending_flags.size() == 0) begin
      $error("trail_followed: expected no transaction, got %b", got);
      mismatches++;
      return;
    end
    want = pending_flags.pop_front();
    pairs_checked++;
    if (got !== want) begin
      $error("trail_followed: expected %b, got %b", want, got);
      mismatches++;
    end else if (want) begin
      trails_followed++;
    end
  endfunction
endclass

module tb_skinny64_pair_trail_check;
  localparam int PAIRS_PER_PHASE = 50;
  localparam int RANDOM_PHASES   = 16;
  localparam int SETTLE_CYCLES   = 4;
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam skn64_pkg::word_t UPPER_KEY_CELLS = 64'hffff_ffff_0000_0000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  skn64_pkg::word_t in_first_plaintext;
  skn64_pkg::word_t in_second_plaintext;
  skn64_pkg::word_t in_first_tweakey;
  skn64_pkg::word_t in_second_tweakey;
  logic             out_valid;
  logic             out_stall;
  logic             out_trail_followed;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [2:0]       cfg_index;
  skn64_pkg::word_t cfg_data;

  trail_tracker trail_book;
  int in_gap_max;
  int out_gap_max;
  skn64_pkg::word_t tpl_p1, tpl_k1, tpl_delta, tpl_kd;

  skinny64_pair_trail_check DUT (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2_000_000;
    $display("tb_skinny64_pair_trail_check: done, errors");
    $finish;
  end

  function automatic skn64_pkg::word_t rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic skn64_pkg::word_t corner_word();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  // Result side: random stall after each accepted transaction.
  initial begin : result_side
    int hold;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        trail_book.check_flag(out_trail_followed);
        hold = $urandom_range(0, out_gap_max);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Leaves in_valid as is after acceptance, so back-to-back pairs keep it high.
  task automatic send_pair(input skn64_pkg::word_t p1, input skn64_pkg::word_t p2,
                           input skn64_pkg::word_t k1, input skn64_pkg::word_t k2);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_plaintext <= p1;
    in_second_plaintext <= p2;
    in_first_tweakey <= k1;
    in_second_tweakey <= k2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    trail_book.note_pair(p1, p2, k1, k2);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (trail_book.pending_flags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic program_reg(input logic [2:0] idx, input skn64_pkg::word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    trail_book.write_reg(idx, data);
  endtask

  // Picks a low-weight difference, runs a sample pair through it and loads the
  // resulting trail, so well-formed pairs have a real chance to follow it.
  task automatic arm_trail(input int rounds);
    skn64_pkg::word_t bef [skn64_pkg::MAX_ROUNDS];
    skn64_pkg::word_t aft [skn64_pkg::MAX_ROUNDS];
    skn64_pkg::word_t rounds_word;
    int pos;
    tpl_p1 = rand64();
    tpl_k1 = rand64();
    tpl_delta = '0;
    repeat ($urandom_range(0, 2)) begin
      pos = $urandom_range(0, skn64_pkg::CELLS - 1);
      tpl_delta[4*pos +: 4] = 4'($urandom_range(1, 15));
    end
    tpl_kd = '0;
    if ($urandom_range(0, 1) == 1) begin
      pos = $urandom_range(0, skn64_pkg::CELLS - 1);
      tpl_kd[4*pos +: 4] = 4'($urandom_range(1, 15));
    end
    trail_book.trace_diffs(tpl_p1, tpl_p1 ^ tpl_delta, tpl_k1, tpl_k1 ^ tpl_kd, bef, aft);
    if ($urandom_range(0, 4) == 0) begin
      pos = $urandom_range(0, skn64_pkg::MAX_ROUNDS - 1);
      if ($urandom_range(0, 1) == 1)
        bef[pos][$urandom_range(0, 63)] ^= 1'b1;
      else
        aft[pos][$urandom_range(0, 63)] ^= 1'b1;
    end
    // rounds past the active count are never compared
    for (int r = rounds; r < skn64_pkg::MAX_ROUNDS; r++)
      if ($urandom_range(0, 1) == 1) begin
        bef[r] = rand64();
        aft[r] = rand64();
      end
    rounds_word = rand64();
    rounds_word[skn64_pkg::ROUNDS_W-1:0] = skn64_pkg::ROUNDS_W'(rounds);
    program_reg(skn64_pkg::CFG_NUM_ROUNDS, rounds_word);
    program_reg(skn64_pkg::CFG_BEFORE_R0, bef[0]);
    program_reg(skn64_pkg::CFG_AFTER_R0, aft[0]);
    program_reg(skn64_pkg::CFG_BEFORE_R1, bef[1]);
    program_reg(skn64_pkg::CFG_AFTER_R1, aft[1]);
    program_reg(skn64_pkg::CFG_BEFORE_R2, bef[2]);
    program_reg(skn64_pkg::CFG_AFTER_R2, aft[2]);
    if ($urandom_range(0, 3) == 0)
      program_reg(CFG_UNUSED, rand64());
    cfg_valid <= 1'b0;
  endtask

  task automatic send_trail_pair();
    skn64_pkg::word_t p1, p2, k1, k2;
    int pick;
    pick = $urandom_range(0, 99);
    p1 = rand64();
    k1 = rand64();
    p2 = p1 ^ tpl_delta;
    k2 = k1 ^ tpl_kd;
    if (pick < 15) begin
      p1 = tpl_p1;
      p2 = tpl_p1 ^ tpl_delta;
      k1 = tpl_k1;
      k2 = tpl_k1 ^ tpl_kd;
    end else if (pick >= 90) begin
      p1 = corner_word();
      p2 = corner_word();
      k1 = corner_word();
      k2 = corner_word();
    end else if (pick >= 80) begin
      p2 = rand64();
      k2 = rand64();
    end else if (pick >= 65) begin
      // one stray bit breaks the difference
      if ($urandom_range(0, 1) == 1)
        p2[$urandom_range(0, 63)] ^= 1'b1;
      else
        k2[$urandom_range(0, 63)] ^= 1'b1;
    end
    send_pair(p1, p2, k1, k2);
  endtask

  initial begin : stimulus
    skn64_pkg::word_t p, k;
    trail_book = new();
    in_gap_max = 8;
    out_gap_max = 8;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_first_plaintext <= '0;
    in_second_plaintext <= '0;
    in_first_tweakey <= '0;
    in_second_tweakey <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset trail: three rounds, every difference zero
    p = rand64();
    k = rand64();
    send_pair('0, '0, '0, '0);
    send_pair('1, '1, '1, '1);
    send_pair(p, p, k, k);
    send_pair(p, p, k, k ^ UPPER_KEY_CELLS);
    send_pair('0, '1, '0, '0);
    drain_results();

    // one round; the all-zero/all-ones pair leaves a difference of 3 in every cell after the S-box
    program_reg(skn64_pkg::CFG_NUM_ROUNDS, 64'hffff_ffff_ffff_fffd);
    program_reg(skn64_pkg::CFG_BEFORE_R0, '1);
    program_reg(skn64_pkg::CFG_AFTER_R0, {16{4'h3}});
    program_reg(CFG_UNUSED, '1);
    cfg_valid <= 1'b0;
    send_pair('0, '1, '1, '0);
    send_pair('1, '0, k, ~k);
    send_pair(p, ~p, k, k);
    send_pair(p, p, k, k ^ UPPER_KEY_CELLS);
    drain_results();

    // zero rounds: nothing checked
    program_reg(skn64_pkg::CFG_NUM_ROUNDS, 64'hffff_ffff_ffff_fffc);
    cfg_valid <= 1'b0;
    send_pair('0, '1, '0, '1);
    send_pair(rand64(), rand64(), rand64(), rand64());
    send_pair(p, ~p, k, ~k);
    drain_results();

    // every register at its top value
    program_reg(skn64_pkg::CFG_NUM_ROUNDS, '1);
    for (int i = skn64_pkg::CFG_BEFORE_R0; i <= skn64_pkg::CFG_AFTER_R2; i++)
      program_reg(3'(i), '1);
    cfg_valid <= 1'b0;
    send_pair('0, '1, '0, '0);
    send_pair('1, '0, '1, '1);
    send_pair(p, p, k, k);
    send_pair(p, ~p, '0, '1);
    drain_results();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      arm_trail((phase % 6 == 5) ? 0 : 1 + phase % 3);
      for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
        send_trail_pair();
        if (phase == 3 && n == PAIRS_PER_PHASE / 2)
          drain_results();
      end
      drain_results();
    end

    $display("tb: %0d pairs checked, %0d followed the loaded trail",
             trail_book.pairs_checked, trail_book.trails_followed);
    $display("tb: 0 to 3 rounds, all registers plus the unused index, gaps up to 8 cycles");
    if (trail_book.mismatches == 0 && trail_book.pending_flags.size() == 0)
      $display("tb_skinny64_pair_trail_check: done, clean");
    else
      $display("tb_skinny64_pair_trail_check: done, errors");
    $finish;
  end
endmodule
